// File: sv/sysex_patch_receiver_assert.svh
// Assertion macros for the checker file of the SysEx patch receiver
`ifndef SYSEX_PATCH_RECEIVER_ASSERT_SVH
`define SYSEX_PATCH_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SPR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SPR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/spr_pkg.sv
// Types and constants of the SysEx patch receiver
`timescale 1ns / 1ps

package spr_pkg;

  localparam int PATCH_BYTES = 256;
  localparam int PRESETS     = 128;
  localparam int NAME_BYTES  = 8;

  localparam logic [7:0] END_BYTE      = 8'hF7;
  localparam logic [7:0] TYPE_PATCH    = 8'h03;
  localparam logic [7:0] TYPE_BANK     = 8'h04;
  localparam logic [7:0] NAME_TMO_BYTE = 8'hFF;

  localparam logic [15:0] MAX_STORE_ADDR =
    16'(NAME_BYTES + PATCH_BYTES * PRESETS - 1);

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_BYTE     = 2'd1,
    OP_TIMEOUT  = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_PATCH_OK  = 3'd0,
    ST_BANK_OK   = 3'd1,
    ST_BAD_TYPE  = 3'd2,
    ST_REFUSED   = 3'd3,
    ST_DATA_TMO  = 3'd4,
    ST_CSUM_BAD  = 3'd5,
    ST_BANK_FAIL = 3'd6,
    ST_EMPTY_TMO = 3'd7
  } status_t;

  typedef enum logic [0:0] {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [0:0] {
    REG_PATCH_ENABLE = 1'b0,
    REG_BANK_ENABLE  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] store_addr;
    logic [7:0]  store_byte;
    logic [2:0]  status;
    logic [7:0]  detail;
  } out_item_t;

  typedef struct packed {
    logic patch_enable;
    logic bank_enable;
  } spr_cfg_t;

endpackage

// File: sv/spr_core.sv
// Message parser: reception state and the result for one item
`timescale 1ns / 1ps

module spr_core
  import spr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  spr_cfg_t  cfg,
  output logic      res_valid,
  output out_item_t res
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_NAME  = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4,
    PH_DRAIN = 3'd5
  } phase_t;

  localparam logic [7:0] PB_LAST  = 8'(PATCH_BYTES - 1);
  localparam logic [6:0] PR_LAST  = 7'(PRESETS - 1);
  localparam logic [2:0] NAME_LAST = 3'(NAME_BYTES - 1);

  phase_t     phase_r, phase_nxt;
  logic       is_bank_r, is_bank_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [6:0] preset_r, preset_nxt;
  logic [6:0] sum_r, sum_nxt;
  status_t    pend_status_r, pend_status_nxt;
  logic [7:0] pend_detail_r, pend_detail_nxt;

  logic       tmo;
  logic [7:0] b;
  logic [7:0] k;
  logic [2:0] name_addr;
  logic       want_bank;
  logic       type_ok;
  status_t    fail_st;
  logic [7:0] fail_det;

  assign tmo       = (item.operation == OP_TIMEOUT);
  assign b         = item.rx_byte;
  assign k         = (byte_count_r > PB_LAST) ? PB_LAST : byte_count_r;
  assign name_addr = byte_count_r[2:0];
  assign want_bank = (b == TYPE_BANK);
  assign type_ok   = want_bank ? cfg.bank_enable : cfg.patch_enable;

  always_comb begin
    phase_nxt       = phase_r;
    is_bank_nxt     = is_bank_r;
    byte_count_nxt  = byte_count_r;
    preset_nxt      = preset_r;
    sum_nxt         = sum_r;
    pend_status_nxt = pend_status_r;
    pend_detail_nxt = pend_detail_r;
    res_valid       = 1'b0;
    res             = '0;
    fail_st         = ST_DATA_TMO;
    fail_det        = k;

    if (step) begin
      case (op_t'(item.operation))
        OP_START: begin
          phase_nxt       = PH_TYPE;
          is_bank_nxt     = 1'b0;
          byte_count_nxt  = '0;
          preset_nxt      = '0;
          sum_nxt         = '0;
          pend_status_nxt = ST_PATCH_OK;
          pend_detail_nxt = '0;
        end
        OP_BYTE, OP_TIMEOUT: begin
          case (phase_r)
            PH_TYPE: begin
              if (tmo || b == END_BYTE) begin
                res_valid  = 1'b1;
                res.kind   = KIND_STATUS;
                res.status = ST_EMPTY_TMO;
                phase_nxt  = PH_IDLE;
              end else if (b == TYPE_PATCH || b == TYPE_BANK) begin
                is_bank_nxt = want_bank;
                if (!type_ok) begin
                  pend_status_nxt = ST_REFUSED;
                  pend_detail_nxt = 8'd1;
                  phase_nxt       = PH_DRAIN;
                end else begin
                  byte_count_nxt = '0;
                  sum_nxt        = '0;
                  phase_nxt      = want_bank ? PH_NAME : PH_DATA;
                end
              end else begin
                res_valid  = 1'b1;
                res.kind   = KIND_STATUS;
                res.status = ST_BAD_TYPE;
                res.detail = 8'd1;
                phase_nxt  = PH_IDLE;
              end
            end
            PH_NAME: begin
              if (name_addr == NAME_LAST) begin
                preset_nxt     = '0;
                byte_count_nxt = '0;
                sum_nxt        = '0;
                phase_nxt      = PH_DATA;
              end else begin
                byte_count_nxt = {5'd0, name_addr} + 8'd1;
              end
              res_valid      = 1'b1;
              res.kind       = KIND_DATA;
              res.store_addr = {13'd0, name_addr};
              res.store_byte = tmo ? NAME_TMO_BYTE : b;
            end
            PH_DATA: begin
              if (tmo) begin
                fail_st  = ST_DATA_TMO;
                fail_det = k;
                pend_status_nxt = is_bank_r ? ST_BANK_FAIL : fail_st;
                pend_detail_nxt = is_bank_r ? {1'b0, preset_r} : fail_det;
                phase_nxt       = PH_DRAIN;
              end else begin
                sum_nxt = sum_r + b[6:0];
                if (k == PB_LAST) begin
                  phase_nxt = PH_CHECK;
                end else begin
                  byte_count_nxt = k + 8'd1;
                end
                res_valid      = 1'b1;
                res.kind       = KIND_DATA;
                res.store_addr = is_bank_r
                  ? 16'(NAME_BYTES) + 16'(preset_r) * 16'(PATCH_BYTES) + {8'd0, k}
                  : {8'd0, k};
                res.store_byte = b;
              end
            end
            PH_CHECK: begin
              if (tmo || b != {1'b0, sum_r}) begin
                fail_st  = tmo ? ST_EMPTY_TMO : ST_CSUM_BAD;
                fail_det = tmo ? 8'd2 : b;
                pend_status_nxt = is_bank_r ? ST_BANK_FAIL : fail_st;
                pend_detail_nxt = is_bank_r ? {1'b0, preset_r} : fail_det;
                phase_nxt       = PH_DRAIN;
              end else if (!is_bank_r) begin
                pend_status_nxt = ST_PATCH_OK;
                pend_detail_nxt = b;
                phase_nxt       = PH_DRAIN;
              end else if (preset_r == PR_LAST) begin
                pend_status_nxt = ST_BANK_OK;
                pend_detail_nxt = '0;
                phase_nxt       = PH_DRAIN;
              end else begin
                preset_nxt     = preset_r + 7'd1;
                byte_count_nxt = '0;
                sum_nxt        = '0;
                phase_nxt      = PH_DATA;
              end
            end
            PH_DRAIN: begin
              if (tmo || b == END_BYTE) begin
                res_valid = 1'b1;
                res.kind  = KIND_STATUS;
                phase_nxt = PH_IDLE;
                // a good body that times out before the end byte
                if (tmo && (pend_status_r == ST_PATCH_OK || pend_status_r == ST_BANK_OK)) begin
                  res.status = ST_EMPTY_TMO;
                  res.detail = 8'd1;
                end else begin
                  res.status = pend_status_r;
                  res.detail = pend_detail_r;
                end
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      is_bank_r     <= 1'b0;
      byte_count_r  <= '0;
      preset_r      <= '0;
      sum_r         <= '0;
      pend_status_r <= ST_PATCH_OK;
      pend_detail_r <= '0;
    end else begin
      phase_r       <= phase_nxt;
      is_bank_r     <= is_bank_nxt;
      byte_count_r  <= byte_count_nxt;
      preset_r      <= preset_nxt;
      sum_r         <= sum_nxt;
      pend_status_r <= pend_status_nxt;
      pend_detail_r <= pend_detail_nxt;
    end
  end

endmodule

// File: sv/sysex_patch_receiver.sv
// Top level of the SysEx patch receiver: item registers, config registers, parser
`timescale 1ns / 1ps

// Parses the body of a MIDI system-exclusive patch or bank dump, one received
// byte (or start / timeout event) per item, and returns at most one result per
// item: a byte to write into patch storage with its address, or the final
// status of the message. The block takes one item every cycle while the result
// channel does not stall; a result passes from the input register through the
// parser into the result register, which drives out_*. Items move only when the
// result register is free or being taken, so a stalled result channel holds
// back at most one further item.
// patch_enable and bank_enable sit at byte addresses 0 and 4 of the APB port,
// both reset to 1; write them only while no message is in flight.
module sysex_patch_receiver
  import spr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  spr_cfg_t  cfg_r;

  logic      advance;
  logic      step;
  logic      res_valid;
  out_item_t res;
  logic      cfg_wr;
  reg_idx_t  reg_sel;

  assign advance  = !out_valid_r || out_ready;
  assign step     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // register file
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_sel)
      REG_PATCH_ENABLE: prdata = {31'd0, cfg_r.patch_enable};
      REG_BANK_ENABLE:  prdata = {31'd0, cfg_r.bank_enable};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.patch_enable <= 1'b1;
      cfg_r.bank_enable  <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_PATCH_ENABLE: cfg_r.patch_enable <= pwdata[0];
        REG_BANK_ENABLE:  cfg_r.bank_enable  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // input item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  spr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (in_data_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_data_r <= res;
    end
  end

endmodule

// File: sv/spr_checker.sv
// Port-level checks for the SysEx patch receiver, bound to the top level
`timescale 1ns / 1ps
`include "sysex_patch_receiver_assert.svh"

module spr_checker
  import spr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input in_item_t    in_data,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic in_stall;
  logic out_stall;
  logic status_clean;
  logic data_clean;
  logic fields_ok;
  logic bad_type;
  logic wr_acc;
  logic wr_seen_r;
  logic wr_addr_r;
  logic wr_bit_r;
  logic cfg_read_back;
  logic read_ok;

  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;

  // unused fields of a result item are zero, and a data item's store address is in range
  assign status_clean = out_data.store_addr == 16'd0 && out_data.store_byte == 8'd0;
  assign data_clean   = out_data.status == ST_PATCH_OK && out_data.detail == 8'd0 &&
                        out_data.store_addr <= MAX_STORE_ADDR;
  assign fields_ok    = (out_data.kind == KIND_STATUS) ? status_clean : data_clean;

  assign bad_type = out_valid && out_data.kind == KIND_STATUS &&
                    out_data.status == ST_BAD_TYPE;

  // a written enable bit reads back on the next cycle
  assign wr_acc = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_seen_r <= 1'b0;
    end else begin
      wr_seen_r <= wr_acc;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= paddr[2];
    wr_bit_r  <= pwdata[0];
  end

  assign cfg_read_back = wr_seen_r && psel && !pwrite && paddr[2] == wr_addr_r;
  assign read_ok       = prdata == {31'd0, wr_bit_r};

  `SPR_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable(in_data), "item not held")

  `SPR_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "result not held")

  `SPR_ASSERT_IMPL(a_out_fields, out_valid, fields_ok, "result fields inconsistent with kind")

  `SPR_ASSERT_IMPL(a_bad_type_detail, bad_type, out_data.detail == 8'd1, "bad type detail")

  `SPR_ASSERT_IMPL(a_cfg_readback, cfg_read_back, read_ok, "config readback mismatch")

endmodule

bind sysex_patch_receiver spr_checker u_spr_checker (.*);
